@@ sv/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the alphabet lookup shared by the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int CMD_DEPTH = 4;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // index of the final result carried by one command
   localparam logic [1:0] LAST_IS_FIRST  = 2'd0;
   localparam logic [1:0] LAST_IS_SECOND = 2'd1;
   localparam logic [1:0] LAST_IS_THIRD  = 2'd2;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       run_last;
      logic       message_end;
   } rsp_type;

   // work handed from front to back: up to three bytes, first byte highest
   typedef struct packed {
      logic [23:0] data;
      logic [1:0]  last_idx;
      logic        byte_valid;
      logic        message_end;
   } cmd_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      logic [7:0] d;
      s.valid = 1'b1;
      d       = 8'd0;
      if (c inside {[8'h41:8'h5A]}) begin
         d = c - 8'h41;
      end else if (c inside {[8'h61:8'h7A]}) begin
         d = c - 8'h61 + 8'd26;
      end else if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30 + 8'd52;
      end else if (c == CHAR_PLUS) begin
         d = 8'd62;
      end else if (c == CHAR_SLASH) begin
         d = 8'd63;
      end else begin
         s.valid = 1'b0;
      end
      s.value = d[5:0];
      return s;
   endfunction

endpackage

@@ sv/b64d_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// b64d_cmd_fifo
// Short queue of decode commands between the front and the back.
// ----------------------------------------------------------------------------
module b64d_cmd_fifo #(
   parameter int DEPTH = b64d_pkg::CMD_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64d_pkg::cmd_type wr_data,
   output logic              full,
   input  logic              pop,
   output b64d_pkg::cmd_type rd_data,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   b64d_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ sv/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Takes characters, tracks sextets and line state, issues decode commands.
// ----------------------------------------------------------------------------
module b64d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64d_pkg::req_type req_data,
   input  logic              cmd_full,
   output logic              full,
   output logic              cmd_push,
   output b64d_pkg::cmd_type cmd_data
);

   logic [17:0] buf_ff, buf_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        after_nl_ff, after_nl_in;
   logic        stopped_ff, stopped_in;
   logic        accept;
   logic        emit_grp;
   logic [23:0] group;
   b64d_pkg::sextet_type sx;

   assign full   = cmd_full;
   assign accept = push && !cmd_full;
   assign sx     = b64d_pkg::sextet_of(req_data.char_in);
   assign group  = {buf_ff, sx.value};

   always_comb begin
      buf_in      = buf_ff;
      cnt_in      = cnt_ff;
      after_nl_in = after_nl_ff;
      stopped_in  = stopped_ff;
      emit_grp    = 1'b0;
      cmd_data    = '0;
      if (!stopped_ff) begin
         if (after_nl_ff) begin
            after_nl_in = 1'b0;
            if (req_data.char_in != b64d_pkg::CHAR_SPACE &&
                req_data.char_in != b64d_pkg::CHAR_TAB) begin
               stopped_in = 1'b1;
            end
         end else if (req_data.char_in == b64d_pkg::CHAR_LF) begin
            after_nl_in = 1'b1;
         end else if (sx.valid) begin
            if (cnt_ff == 2'd3) begin
               emit_grp = 1'b1;
               buf_in   = '0;
               cnt_in   = '0;
            end else begin
               buf_in = {buf_ff[11:0], sx.value};
               cnt_in = cnt_ff + 2'd1;
            end
         end
      end

      if (emit_grp) begin
         cmd_data.data       = group;
         cmd_data.last_idx   = b64d_pkg::LAST_IS_THIRD;
         cmd_data.byte_valid = 1'b1;
      end else if (cnt_in == 2'd3) begin
         cmd_data.data       = {buf_in, 6'd0};
         cmd_data.last_idx   = b64d_pkg::LAST_IS_SECOND;
         cmd_data.byte_valid = 1'b1;
      end else if (cnt_in == 2'd2) begin
         cmd_data.data       = {buf_in[11:0], 12'd0};
         cmd_data.last_idx   = b64d_pkg::LAST_IS_FIRST;
         cmd_data.byte_valid = 1'b1;
      end else begin
         cmd_data.last_idx   = b64d_pkg::LAST_IS_FIRST;
      end
      cmd_data.message_end = req_data.end_of_text;

      // end of string: flush and return to the idle state
      if (req_data.end_of_text) begin
         buf_in      = '0;
         cnt_in      = '0;
         after_nl_in = 1'b0;
         stopped_in  = 1'b0;
      end
   end

   assign cmd_push = accept && (emit_grp || req_data.end_of_text);

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff      <= '0;
         cnt_ff      <= '0;
         after_nl_ff <= 1'b0;
         stopped_ff  <= 1'b0;
      end else if (accept) begin
         buf_ff      <= buf_in;
         cnt_ff      <= cnt_in;
         after_nl_ff <= after_nl_in;
         stopped_ff  <= stopped_in;
      end
   end

endmodule

@@ sv/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Expands each command into results, one per cycle while the output is empty or popped, into the output register.
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  b64d_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              empty,
   input  logic              pop,
   output b64d_pkg::rsp_type rsp_data
);

   logic              out_valid_ff, out_valid_in;
   b64d_pkg::rsp_type out_ff, out_in;
   logic [1:0]        pos_ff, pos_in;
   logic              advance;
   logic              at_last;

   assign advance  = !out_valid_ff || pop;
   assign at_last  = (pos_ff == cmd_data.last_idx);
   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      pos_in       = pos_ff;
      cmd_pop      = 1'b0;
      if (advance) begin
         out_valid_in = !cmd_empty;
         if (!cmd_empty) begin
            case (pos_ff)
               b64d_pkg::LAST_IS_FIRST:  out_in.data_byte = cmd_data.data[23:16];
               b64d_pkg::LAST_IS_SECOND: out_in.data_byte = cmd_data.data[15:8];
               default:                  out_in.data_byte = cmd_data.data[7:0];
            endcase
            out_in.byte_valid  = cmd_data.byte_valid;
            out_in.run_last    = at_last;
            out_in.message_end = at_last && cmd_data.message_end;
            if (at_last) begin
               cmd_pop = 1'b1;
               pos_in  = '0;
            end else begin
               pos_in = pos_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

@@ sv/base64_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming base64 text decoder, one character per request.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while full is low. The front
// classifies it in the same cycle and, when a group of four sextets completes
// or the string ends, writes a command of one to three results into a
// CMD_DEPTH-entry queue; the back emits one result per cycle from that queue
// into the output register while that register is empty or popped. A result
// passes through the command queue and then the output register. Four characters
// give three bytes, so input runs at full rate as long as the consumer pops each
// cycle; full rises only when the command queue is filled by a stalled consumer.
module base64_stream_decoder_unit #(
   parameter int CMD_DEPTH = b64d_pkg::CMD_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  b64d_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output b64d_pkg::rsp_type rsp_data
);

   logic              cmd_push, cmd_pop, cmd_full, cmd_empty;
   b64d_pkg::cmd_type cmd_wr, cmd_rd;

   b64d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .cmd_full (cmd_full),
      .full     (full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wr)
   );

   b64d_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rd),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

   // end of string always produces a command
   a_end_cmd: assert property (@(posedge clock) disable iff (reset)
      push && !full && req_data.end_of_text |-> cmd_push)
      else $error("end of string produced no command");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.message_end |-> rsp_data.run_last)
      else $error("message end without run last");

   a_marker: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_data.byte_valid |->
         rsp_data.message_end && rsp_data.data_byte == 8'd0)
      else $error("malformed empty end marker");

   a_reset: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("not idle after reset");

endmodule
